### rtl/sra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the service registry with slot aging.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int Q_DEPTH   = 2;

    localparam logic [15:0] LIFETIME_RST = 16'd60;
    localparam logic [63:0] TS_KEY_RST   = 64'd0;

    typedef enum logic {
        CFG_LIFETIME = 1'b0,
        CFG_TS_KEY   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DROP_NONE  = 2'd0,
        DROP_RANGE = 2'd1,
        DROP_EMPTY = 2'd2
    } drop_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_ALLOC,
        BK_DEST,
        BK_FIN
    } bk_state_t;

    // classified message as it travels from front to back
    typedef struct packed {
        logic [63:0] skey;
        logic [7:0]  dport;
        logic [31:0] now;
        logic [31:0] new_exp;
        logic        oor;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/sra_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_front
// Input stage: takes message transfers, computes the refresh expiry and the
// destination range check, and hands classified messages to the queue.
// ----------------------------------------------------------------------------
module sra_front
    import sra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] sender_key,
    input  wire logic [7:0]  dest_port,
    input  wire logic [31:0] now_seconds,
    input  wire logic [15:0] lifetime,
    output logic             push,
    output cmd_t             push_cmd,
    input  wire logic        q_full
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        valid_next = accept || (valid_reg && !push);
        cmd_next   = cmd_reg;
        if (accept)
        begin
            cmd_next.skey    = sender_key;
            cmd_next.dport   = dest_port;
            cmd_next.now     = now_seconds;
            cmd_next.new_exp = now_seconds + 32'(lifetime);
            cmd_next.oor     = 32'(dest_port) >= 32'(SLOTS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### rtl/sra_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_queue
// Short FIFO of classified messages between the front and the back.
// ----------------------------------------------------------------------------
module sra_queue
    import sra_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    cmd_t          entry_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = count_reg == CW'(Q_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/sra_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_back
// Slot engine: sweeps the slot table one slot per cycle, ages out expired
// slots, refreshes or allocates the sender, looks up the destination and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module sra_back
    import sra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] ts_key,
    input  wire logic        q_valid,
    input  wire cmd_t        q_cmd,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       sender_port,
    output logic             table_full,
    output logic             forward_ok,
    output logic [63:0]      dest_key,
    output logic [1:0]       drop_reason
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    bk_state_t      state_reg;
    bk_state_t      state_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    cmd_t           cmd_reg;
    cmd_t           cmd_next;
    logic           found_reg;
    logic           found_next;
    logic [IW-1:0]  found_slot_reg;
    logic [IW-1:0]  found_slot_next;
    logic           have_free_reg;
    logic           have_free_next;
    logic [IW-1:0]  free_slot_reg;
    logic [IW-1:0]  free_slot_next;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [IW-1:0]  sport_reg;
    logic [IW-1:0]  sport_next;
    logic           full_reg;
    logic           full_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    logic [3:0]     o_sport_reg;
    logic [3:0]     o_sport_next;
    logic           o_full_reg;
    logic           o_full_next;
    logic           o_fwd_reg;
    logic           o_fwd_next;
    logic [63:0]    o_dkey_reg;
    logic [63:0]    o_dkey_next;
    drop_t          o_reason_reg;
    drop_t          o_reason_next;

    logic [63:0]    key_mem [SLOTS];
    logic [31:0]    exp_mem [SLOTS];
    logic [63:0]    rd_key_reg;
    logic [31:0]    rd_exp_reg;
    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  wr_addr;
    logic           key_we;
    logic           exp_we;

    logic [CW-1:0]  cnt_m1;
    logic [IW-1:0]  proc_idx;
    logic [63:0]    proc_key;
    logic [IW-1:0]  dst_idx;
    logic [63:0]    dst_key;

    assign cnt_m1    = cnt_reg - CW'(1);
    assign proc_idx  = cnt_m1[IW-1:0];
    assign proc_key  = (proc_idx == '0) ? ts_key : rd_key_reg;
    assign dst_idx   = cmd_reg.dport[IW-1:0];
    assign dst_key   = (dst_idx == '0) ? ts_key : rd_key_reg;

    assign out_valid   = out_valid_reg;
    assign sender_port = o_sport_reg;
    assign table_full  = o_full_reg;
    assign forward_ok  = o_fwd_reg;
    assign dest_key    = o_dkey_reg;
    assign drop_reason = o_reason_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        have_free_next  = have_free_reg;
        free_slot_next  = free_slot_reg;
        valid_next      = valid_reg;
        sport_next      = sport_reg;
        full_next       = full_reg;
        out_valid_next  = out_valid_reg && out_stall;
        o_sport_next    = o_sport_reg;
        o_full_next     = o_full_reg;
        o_fwd_next      = o_fwd_reg;
        o_dkey_next     = o_dkey_reg;
        o_reason_next   = o_reason_reg;
        pop             = 1'b0;
        rd_addr         = cnt_reg[IW-1:0];
        wr_addr         = proc_idx;
        key_we          = 1'b0;
        exp_we          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop             = 1'b1;
                    cmd_next        = q_cmd;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    found_slot_next = '0;
                    have_free_next  = 1'b0;
                    free_slot_next  = '0;
                    state_next      = BK_SWEEP;
                end
            end
            BK_SWEEP:
            begin
                if (cnt_reg != '0)
                begin
                    if (!valid_reg[proc_idx])
                    begin
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_slot_next = proc_idx;
                        end
                    end
                    else if (proc_idx != '0 && rd_exp_reg <= cmd_reg.now)
                    begin
                        valid_next[proc_idx] = 1'b0;
                        if (!have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_slot_next = proc_idx;
                        end
                    end
                    else if (proc_key == cmd_reg.skey)
                    begin
                        found_next      = 1'b1;
                        found_slot_next = proc_idx;
                        exp_we          = 1'b1;
                    end
                end
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = BK_ALLOC;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            BK_ALLOC:
            begin
                full_next = 1'b0;
                wr_addr   = free_slot_reg;
                if (found_reg)
                begin
                    sport_next = found_slot_reg;
                end
                else if (have_free_reg)
                begin
                    valid_next[free_slot_reg] = 1'b1;
                    key_we     = 1'b1;
                    exp_we     = 1'b1;
                    sport_next = free_slot_reg;
                end
                else
                begin
                    full_next  = 1'b1;
                    sport_next = '0;
                end
                state_next = BK_DEST;
            end
            BK_DEST:
            begin
                rd_addr    = dst_idx;
                state_next = BK_FIN;
            end
            BK_FIN:
            begin
                // keep the destination key in the read register while stalled
                rd_addr = dst_idx;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_sport_next   = 4'(sport_reg);
                    o_full_next    = full_reg;
                    if (cmd_reg.oor)
                    begin
                        o_fwd_next    = 1'b0;
                        o_dkey_next   = '0;
                        o_reason_next = DROP_RANGE;
                    end
                    else if (!valid_reg[dst_idx])
                    begin
                        o_fwd_next    = 1'b0;
                        o_dkey_next   = '0;
                        o_reason_next = DROP_EMPTY;
                    end
                    else
                    begin
                        o_fwd_next    = 1'b1;
                        o_dkey_next   = dst_key;
                        o_reason_next = DROP_NONE;
                    end
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
            valid_reg     <= SLOTS'(1);
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            have_free_reg <= have_free_next;
            valid_reg     <= valid_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        found_slot_reg <= found_slot_next;
        free_slot_reg  <= free_slot_next;
        sport_reg      <= sport_next;
        o_sport_reg    <= o_sport_next;
        o_full_reg     <= o_full_next;
        o_fwd_reg      <= o_fwd_next;
        o_dkey_reg     <= o_dkey_next;
        o_reason_reg   <= o_reason_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= cmd_reg.skey;
        end
        if (exp_we)
        begin
            exp_mem[wr_addr] <= cmd_reg.new_exp;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_exp_reg <= exp_mem[rd_addr];
    end

    a_slot0_kept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |=> valid_reg[0])
        else $error("slot zero lost its valid bit");

    a_full_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_full_reg |-> o_sport_reg == 4'd0)
        else $error("table full with nonzero sender port");

    a_fwd_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (o_fwd_reg == (o_reason_reg == DROP_NONE)))
        else $error("forward flag disagrees with drop reason");

    a_drop_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !o_fwd_reg |-> o_dkey_reg == 64'd0)
        else $error("dropped message carries a key");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_SWEEP && cnt_reg == CW'(SLOTS) |=> state_reg == BK_ALLOC)
        else $error("sweep did not end in allocation");

endmodule

`default_nettype wire

### rtl/service_registry_with_aging_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// service_registry_with_aging_unit
// Slot registry with aging: frees expired slots, refreshes or allocates the
// sender at the lowest free slot and resolves the destination port to a key.
// ----------------------------------------------------------------------------
// In the slot engine each message passes through the sweep, which reads one
// slot per cycle from the key/expiry memory, then allocation, destination
// read and result load. Up to three messages can be held ahead of the engine
// (input register and a two-entry queue), and a finished result waits in the
// output register while the next message is already in work. Slot zero
// always holds the time server key. Configuration writes are to be made only
// while no message is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module service_registry_with_aging_unit
    import sra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] sender_key,
    input  wire logic [7:0]  dest_port,
    input  wire logic [31:0] now_seconds,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       sender_port,
    output logic             table_full,
    output logic             forward_ok,
    output logic [63:0]      dest_key,
    output logic [1:0]       drop_reason
);

    logic [15:0] lifetime_reg;
    logic [15:0] lifetime_next;
    logic [63:0] ts_key_reg;
    logic [63:0] ts_key_next;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    always_comb
    begin
        lifetime_next = lifetime_reg;
        ts_key_next   = ts_key_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LIFETIME: lifetime_next = cfg_wdata[15:0];
                CFG_TS_KEY:   ts_key_next   = cfg_wdata;
                default:      lifetime_next = lifetime_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RST;
            ts_key_reg   <= TS_KEY_RST;
        end
        else
        begin
            lifetime_reg <= lifetime_next;
            ts_key_reg   <= ts_key_next;
        end
    end

    sra_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sender_key (sender_key),
        .dest_port  (dest_port),
        .now_seconds(now_seconds),
        .lifetime   (lifetime_reg),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    sra_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .head_valid(q_valid),
        .head_cmd  (q_cmd)
    );

    sra_back #(
        .SLOTS(SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ts_key     (ts_key_reg),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sender_port(sender_port),
        .table_full (table_full),
        .forward_ok (forward_ok),
        .dest_key   (dest_key),
        .drop_reason(drop_reason)
    );

endmodule

`default_nettype wire

### verif/registry_checker.sv
// ----------------------------------------------------------------------------
// registry_checker
// Watches the message and result channels of the service registry and the
// register write port. Keeps its own slot table with aging, predicts the
// routing result of every accepted message and compares each returned result
// field by field, in order. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module registry_checker
    import sra_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] sender_key,
    input  logic [7:0]  dest_port,
    input  logic [31:0] now_seconds,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  sender_port,
    input  logic        table_full,
    input  logic        forward_ok,
    input  logic [63:0] dest_key,
    input  logic [1:0]  drop_reason,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [3:0]  sport;
        logic        full;
        logic        fwd;
        logic [63:0] dkey;
        drop_t       reason;
    } routing_t;

    routing_t    routing_q[$];

    logic        occupied   [SLOTS];
    logic [63:0] owner      [SLOTS];
    logic [31:0] expires_at [SLOTS];
    logic [15:0] lifetime;

    // sweep with aging, refresh or allocate the sender, then resolve the port
    function automatic routing_t route_message(
        input logic [63:0] key,
        input logic [7:0]  port,
        input logic [31:0] now
    );
        routing_t    r;
        logic [31:0] renew;
        int          free_idx;
        int          hit_idx;
        int          n;
        renew    = now + {16'd0, lifetime};
        free_idx = -1;
        hit_idx  = -1;
        r        = '0;
        r.reason = DROP_NONE;
        for (n = 0; n < SLOTS; n++)
        begin
            if (occupied[n] && n != 0 && expires_at[n] <= now)
                occupied[n] = 1'b0;
            if (!occupied[n])
            begin
                if (free_idx < 0)
                    free_idx = n;
            end
            else if (owner[n] == key)
            begin
                hit_idx       = n;
                expires_at[n] = renew;
            end
        end
        if (hit_idx >= 0)
            r.sport = hit_idx[3:0];
        else if (free_idx >= 0)
        begin
            occupied[free_idx]   = 1'b1;
            owner[free_idx]      = key;
            expires_at[free_idx] = renew;
            r.sport              = free_idx[3:0];
        end
        else
            r.full = 1'b1;
        if (port >= SLOTS)
            r.reason = DROP_RANGE;
        else if (!occupied[port])
            r.reason = DROP_EMPTY;
        else
        begin
            r.fwd  = 1'b1;
            r.dkey = owner[port];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        routing_t want;
        logic     bad;
        if (!rst_n)
        begin
            routing_q.delete();
            for (int n = 0; n < SLOTS; n++)
            begin
                occupied[n]   = (n == 0);
                owner[n]      = '0;
                expires_at[n] = '0;
            end
            owner[0]   = TS_KEY_RST;
            lifetime   = LIFETIME_RST;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_LIFETIME)
                    lifetime = cfg_wdata[15:0];
                else
                    owner[0] = cfg_wdata;
            end
            if (out_valid && !out_stall)
            begin
                if (routing_q.size() == 0)
                begin
                    $error("result transfer with no message outstanding");
                    bad = 1'b1;
                end
                else
                begin
                    want = routing_q.pop_front();
                    if (sender_port !== want.sport)
                    begin
                        $error("sender_port: expected %0d, got %0d", want.sport, sender_port);
                        bad = 1'b1;
                    end
                    if (table_full !== want.full)
                    begin
                        $error("table_full: expected %0d, got %0d", want.full, table_full);
                        bad = 1'b1;
                    end
                    if (forward_ok !== want.fwd)
                    begin
                        $error("forward_ok: expected %0d, got %0d", want.fwd, forward_ok);
                        bad = 1'b1;
                    end
                    if (dest_key !== want.dkey)
                    begin
                        $error("dest_key: expected %h, got %h", want.dkey, dest_key);
                        bad = 1'b1;
                    end
                    if (drop_reason !== want.reason)
                    begin
                        $error("drop_reason: expected %0d, got %0d", want.reason, drop_reason);
                        bad = 1'b1;
                    end
                end
            end
            if (in_valid && !in_stall)
                routing_q.push_back(route_message(sender_key, dest_port, now_seconds));
            if (bad)
                fail_count <= fail_count + 1;
            pending <= routing_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the service registry with slot aging. A directed
// pass fills, overflows and ages the slot table, then random phases under
// several lifetime and time server settings send well-formed message streams
// from a small key pool mixed with noise, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import sra_pkg::*;

    localparam int SETTLE     = 32;
    localparam int QUIET_MAX  = 4000;
    localparam int POOL       = 24;
    localparam int PHASE_MSGS = 140;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_we      = 1'b0;
    cfg_idx_t    cfg_index   = CFG_LIFETIME;
    logic [63:0] cfg_wdata   = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [63:0] sender_key  = '0;
    logic [7:0]  dest_port   = '0;
    logic [31:0] now_seconds = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [3:0]  sender_port;
    logic        table_full;
    logic        forward_ok;
    logic [63:0] dest_key;
    logic [1:0]  drop_reason;
    int          fail_count;
    int          pending;

    int          sent        = 0;
    int          received    = 0;
    int          stall_left  = 0;
    int          quiet       = 0;

    service_registry_with_aging_unit i_dut (.*);

    registry_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random stall after each transfer, calm stretches included
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        int d;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            received   <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            d = (received % 40 < 8) ? 0 : $urandom_range(0, 16);
            received   <= received + 1;
            stall_left <= d;
            out_stall  <= (d != 0);
        end
        else if (out_valid && stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        @(posedge clk);
        while (quiet < QUIET_MAX)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_msg(input logic [63:0] key, input logic [7:0] port,
                            input logic [31:0] t);
        int gap;
        gap = (sent % 40 < 8) ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sender_key  <= key;
        dest_port   <= port;
        now_seconds <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // hold off until every result is back and the engine has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] life, input logic [63:0] ts);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LIFETIME;
        cfg_wdata <= {48'd0, life};
        @(posedge clk);
        cfg_index <= CFG_TS_KEY;
        cfg_wdata <= ts;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] life, input logic [63:0] ts,
                             input logic [31:0] t0, input int step_max);
        logic [63:0] pool [POOL];
        logic [31:0] wall;
        logic [63:0] key;
        logic [7:0]  port;
        logic [31:0] t;
        int          roll;
        drain();
        configure(life, ts);
        for (int i = 0; i < POOL; i++)
            pool[i] = {$urandom(), $urandom()};
        pool[0] = ts;
        wall = t0;
        repeat (PHASE_MSGS)
        begin
            roll = $urandom_range(0, 99);
            wall = wall + 32'($urandom_range(0, step_max));
            key  = pool[$urandom_range(0, POOL - 1)];
            port = 8'($urandom_range(0, 15));
            t    = wall;
            if (roll < 10)
                key = {$urandom(), $urandom()};
            else if (roll < 18)
                port = 8'($urandom_range(0, 255));
            else if (roll < 24)
                t = $urandom();
            send_msg(key, port, t);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: lifetime 60, time server key zero
        send_msg(64'd0, 8'd0, 32'd10);
        send_msg(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 32'd10);
        send_msg(64'hA5A5_5A5A_A5A5_5A5A, 8'd16, 32'd10);
        send_msg(64'h0000_0000_0000_0001, 8'd15, 32'd10);
        for (int i = 4; i < 16; i++)
            send_msg({32'hC0DE_0000, 32'(i)}, 8'(i - 1), 32'd20);
        send_msg(64'h0123_4567_89AB_CDEF, 8'd15, 32'd30);
        send_msg(64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 32'd50);
        send_msg(64'h5555_5555_5555_5555, 8'd3, 32'd70);
        send_msg(64'd0, 8'd0, 32'hFFFF_FFF0);
        send_msg(64'h8000_0000_0000_0000, 8'd1, 32'hFFFF_FFFF);
        send_msg(64'h8000_0000_0000_0000, 8'd1, 32'd5);

        run_phase(16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 2);
        run_phase(16'hFFFF, {$urandom(), $urandom()}, $urandom(), 4);
        run_phase(16'd60, 64'd0, 32'd1000, 8);
        run_phase(16'($urandom_range(10, 200)), {$urandom(), $urandom()},
                  32'hFFFF_FF80, 6);
        run_phase(16'($urandom_range(1, 65535)), {$urandom(), $urandom()},
                  $urandom(), $urandom_range(1, 3000));
        run_phase(16'd20, 64'd1, 32'd5, 3);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
